// File: rtl/sssu_pkg.sv
`default_nettype none

package sssu_pkg;

    // Fixed field widths
    localparam int ENABLE_W   = 4;
    localparam int SEG_W      = 7;
    localparam int FRAME_OUT_W = 4;
    localparam int CODE_W     = 4;
    localparam int DIGITS_W   = 32;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHOWN_DIGITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SCANS   = 1'd1;

    // Register reset values
    localparam logic [DIGITS_W-1:0] SHOWN_DIGITS_RESET = 32'd0;
    localparam logic [HOLD_W-1:0]   HOLD_SCANS_RESET   = 8'd20;

    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    // One result word
    typedef struct packed {
        logic [ENABLE_W-1:0]    digit_enable;
        logic [SEG_W-1:0]       segments;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic                   frame_done;
    } t_result;

    // Digit code to segments, bit 0 is segment a; codes above nine are blank
    function automatic logic [SEG_W-1:0] seg_decode(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sssu_place_dec.sv
`default_nettype none

// Segment pattern for one place of the padded digit sequence
module sssu_place_dec #(
    parameter int DISPLAY_POSITIONS = 4,
    parameter int SEQUENCE_DIGITS   = 8,
    parameter int PLACE_W           = 5
) (
    input  wire logic [PLACE_W-1:0]              i_place,
    input  wire logic [sssu_pkg::DIGITS_W-1:0]   i_shown_digits,
    output logic      [sssu_pkg::SEG_W-1:0]      o_segments
);

    localparam int IDX_W = (SEQUENCE_DIGITS > 1) ? $clog2(SEQUENCE_DIGITS) : 1;
    localparam logic [PLACE_W-1:0] LEAD = PLACE_W'(DISPLAY_POSITIONS - 1);
    localparam logic [PLACE_W-1:0] TAIL = PLACE_W'(DISPLAY_POSITIONS - 1 + SEQUENCE_DIGITS);

    logic [sssu_pkg::CODE_W-1:0] w_codes [SEQUENCE_DIGITS];
    logic [PLACE_W-1:0]          w_offset;
    logic [IDX_W-1:0]            w_idx;
    logic                        w_in_seq;

    // Split the register into digit codes; digits past bit 31 read as zero
    for (genvar g = 0; g < SEQUENCE_DIGITS; g++) begin : g_code
        localparam int SH = 4 * (SEQUENCE_DIGITS - 1 - g);
        if (SH < sssu_pkg::DIGITS_W) begin : g_in
            assign w_codes[g] = i_shown_digits[SH +: sssu_pkg::CODE_W];
        end else begin : g_out
            assign w_codes[g] = '0;
        end
    end

    // Blank window before and after the digits
    assign w_in_seq = (i_place >= LEAD) && (i_place < TAIL);
    assign w_offset = i_place - LEAD;
    assign w_idx    = w_offset[IDX_W-1:0];

    always_comb begin
        if (w_in_seq) begin
            o_segments = sssu_pkg::seg_decode(w_codes[w_idx]);
        end else begin
            o_segments = sssu_pkg::SEG_BLANK;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sssu_scan_ctrl.sv
`default_nettype none

// Slot, scan and frame counters; builds the result word for each tick
module sssu_scan_ctrl #(
    parameter int DISPLAY_POSITIONS = 4,
    parameter int SEQUENCE_DIGITS   = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic                            i_slot_tick,
    input  wire logic [sssu_pkg::DIGITS_W-1:0]   i_shown_digits,
    input  wire logic [sssu_pkg::HOLD_W-1:0]     i_hold_scans,
    output sssu_pkg::t_result                    o_result
);

    localparam int FRAMES  = DISPLAY_POSITIONS + SEQUENCE_DIGITS;
    localparam int SLOT_W  = $clog2(DISPLAY_POSITIONS + 1);
    localparam int FRAME_W = $clog2(FRAMES);
    localparam int PLACE_W = $clog2(FRAMES + DISPLAY_POSITIONS - 1);
    localparam logic [SLOT_W-1:0]  DARK_SLOT  = SLOT_W'(DISPLAY_POSITIONS);
    localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAMES - 1);

    logic [SLOT_W-1:0]           r_slot;
    logic [sssu_pkg::HOLD_W-1:0] r_scan;
    logic [FRAME_W-1:0]          r_frame;
    logic [sssu_pkg::SEG_W-1:0]  r_held;

    logic                             w_lit;
    logic                             w_frame_end;
    logic [PLACE_W-1:0]               w_place;
    logic [sssu_pkg::SEG_W-1:0]       w_dec_seg;
    logic [sssu_pkg::ENABLE_W-1:0]    w_enable;
    logic [sssu_pkg::FRAME_OUT_W-1:0] w_frame_out;

    assign w_lit       = (r_slot < DARK_SLOT);
    assign w_frame_end = (r_scan >= i_hold_scans);
    assign w_place     = PLACE_W'(r_frame) + PLACE_W'(r_slot);

    sssu_place_dec #(
        .DISPLAY_POSITIONS (DISPLAY_POSITIONS),
        .SEQUENCE_DIGITS   (SEQUENCE_DIGITS),
        .PLACE_W           (PLACE_W)
    ) u_place_dec (
        .i_place        (w_place),
        .i_shown_digits (i_shown_digits),
        .o_segments     (w_dec_seg)
    );

    // Digit line k is lit on slot DISPLAY_POSITIONS-1-k; leftmost goes first
    for (genvar k = 0; k < sssu_pkg::ENABLE_W; k++) begin : g_en
        localparam int K_SLOT = DISPLAY_POSITIONS - 1 - k;
        if (K_SLOT >= 0) begin : g_on
            assign w_enable[k] = (r_slot == SLOT_W'(K_SLOT));
        end else begin : g_off
            assign w_enable[k] = 1'b0;
        end
    end

    // Frame number is cut or zero-extended to the output width
    if (FRAME_W >= sssu_pkg::FRAME_OUT_W) begin : g_fr_cut
        assign w_frame_out = r_frame[sssu_pkg::FRAME_OUT_W-1:0];
    end else begin : g_fr_ext
        assign w_frame_out = sssu_pkg::FRAME_OUT_W'(r_frame);
    end

    // Result word; an idle tick shows dark with held segments
    always_comb begin
        o_result.frame_index = w_frame_out;
        if (i_slot_tick) begin
            o_result.digit_enable = w_enable;
            o_result.segments     = w_lit ? w_dec_seg : r_held;
            o_result.frame_done   = !w_lit && w_frame_end;
        end else begin
            o_result.digit_enable = '0;
            o_result.segments     = r_held;
            o_result.frame_done   = 1'b0;
        end
    end

    // Counter advance on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_scan  <= '0;
            r_frame <= '0;
            r_held  <= sssu_pkg::SEG_BLANK;
        end else if (i_fire && i_slot_tick) begin
            if (w_lit) begin
                r_held <= w_dec_seg;
            end
            if (r_slot == DARK_SLOT) begin
                r_slot <= '0;
                if (w_frame_end) begin
                    r_scan  <= '0;
                    r_frame <= (r_frame == LAST_FRAME) ? '0 : r_frame + 1'b1;
                end else begin
                    r_scan <= r_scan + 1'b1;
                end
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // Checks
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= DARK_SLOT)
        else $error("slot counter out of range");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame <= LAST_FRAME)
        else $error("frame counter out of range");

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_slot_tick && r_slot == DARK_SLOT && w_frame_end)
            |=> (r_scan == '0 && r_slot == '0))
        else $error("frame end did not restart scan");

endmodule

`default_nettype wire

// File: rtl/scrolling_seven_segment_scanner_unit.sv
`default_nettype none

// Latency: a result word appears in the cycle after its tick word is taken.
// Throughput: one tick word per cycle; a new tick is taken in the cycle the
// held result leaves, and the input stalls while a result waits unread.
// Reset (synchronous, active low): slot, scan and frame counters and held
// segments go to zero, shown_digits to 0, hold_scans to 20, output empty.
module scrolling_seven_segment_scanner_unit #(
    parameter int DISPLAY_POSITIONS = 4,
    parameter int SEQUENCE_DIGITS   = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config port
    input  wire logic                               i_cfg_we,
    input  wire logic [sssu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sssu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // tick words in
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_slot_tick,
    // result words out
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [sssu_pkg::ENABLE_W-1:0]           o_digit_enable,
    output logic [sssu_pkg::SEG_W-1:0]              o_segments,
    output logic [sssu_pkg::FRAME_OUT_W-1:0]        o_frame_index,
    output logic                                    o_frame_done
);

    logic [sssu_pkg::DIGITS_W-1:0] r_shown_digits;
    logic [sssu_pkg::HOLD_W-1:0]   r_hold_scans;
    sssu_pkg::t_result             r_out;
    logic                          r_out_valid;

    sssu_pkg::t_result             w_result;
    logic                          w_fire;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown_digits <= sssu_pkg::SHOWN_DIGITS_RESET;
            r_hold_scans   <= sssu_pkg::HOLD_SCANS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sssu_pkg::REG_SHOWN_DIGITS: r_shown_digits <= i_cfg_data;
                sssu_pkg::REG_HOLD_SCANS:
                    r_hold_scans <= i_cfg_data[sssu_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input side takes a word whenever the output slot is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    sssu_scan_ctrl #(
        .DISPLAY_POSITIONS (DISPLAY_POSITIONS),
        .SEQUENCE_DIGITS   (SEQUENCE_DIGITS)
    ) u_scan_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_slot_tick    (i_slot_tick),
        .i_shown_digits (r_shown_digits),
        .i_hold_scans   (r_hold_scans),
        .o_result       (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_digit_enable = r_out.digit_enable;
    assign o_segments     = r_out.segments;
    assign o_frame_index  = r_out.frame_index;
    assign o_frame_done   = r_out.frame_done;

    // Checks
    a_fire_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("accepted word produced no result");

    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out.digit_enable))
        else $error("more than one digit line lit");

    a_done_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |-> (r_out.digit_enable == '0))
        else $error("frame done on a lit slot");

endmodule

`default_nettype wire
